@@ hdl/pfe_pkg.sv @@
// Shared types, key-square tables and the digraph cipher function for the
// Playfair digraph encryptor. No dependencies.
`default_nettype none

package pfe_pkg;

    localparam logic [6:0] ASCII_A = 7'd97;
    localparam logic [6:0] ASCII_Z = 7'd122;
    localparam logic [4:0] LTR_I   = 5'd8;
    localparam logic [4:0] LTR_J   = 5'd9;
    localparam logic [4:0] LTR_Q   = 5'd16;
    localparam logic [4:0] LTR_X   = 5'd23;
    localparam logic [2:0] SQ_LAST = 3'd4;

    // One digraph waiting for the cipher; twice repeats the same pair.
    typedef struct packed {
        logic [4:0] first;
        logic [4:0] second;
        logic       twice;
    } pfe_job_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } pfe_pos_t;

    typedef struct packed {
        logic [6:0] ea;
        logic [6:0] eb;
    } pfe_pair_t;

    function automatic logic [4:0] pfe_filler(input logic [4:0] idx);
        return (idx == LTR_X) ? LTR_Q : LTR_X;
    endfunction

    // Place of each letter index in the square; 'j' shares the place of 'i'.
    function automatic pfe_pos_t pfe_place(input logic [4:0] idx);
        pfe_pos_t p;
        case (idx)
            5'd0:    p = '{3'd1, 3'd3};
            5'd1:    p = '{3'd2, 3'd0};
            5'd2:    p = '{3'd1, 3'd1};
            5'd3:    p = '{3'd2, 3'd1};
            5'd4:    p = '{3'd0, 3'd0};
            5'd5:    p = '{3'd2, 3'd2};
            5'd6:    p = '{3'd2, 3'd3};
            5'd7:    p = '{3'd1, 3'd2};
            5'd8:    p = '{3'd0, 3'd4};
            5'd9:    p = '{3'd0, 3'd4};
            5'd10:   p = '{3'd2, 3'd4};
            5'd11:   p = '{3'd3, 3'd0};
            5'd12:   p = '{3'd0, 3'd2};
            5'd13:   p = '{3'd3, 3'd1};
            5'd14:   p = '{3'd1, 3'd0};
            5'd15:   p = '{3'd0, 3'd3};
            5'd16:   p = '{3'd3, 3'd2};
            5'd17:   p = '{3'd3, 3'd3};
            5'd18:   p = '{3'd0, 3'd1};
            5'd19:   p = '{3'd3, 3'd4};
            5'd20:   p = '{3'd4, 3'd0};
            5'd21:   p = '{3'd1, 3'd4};
            5'd22:   p = '{3'd4, 3'd1};
            5'd23:   p = '{3'd4, 3'd2};
            5'd24:   p = '{3'd4, 3'd3};
            5'd25:   p = '{3'd4, 3'd4};
            default: p = '{3'd0, 3'd0};
        endcase
        return p;
    endfunction

    function automatic logic [6:0] pfe_square(input logic [2:0] row, input logic [2:0] col);
        logic [7:0] c;
        case ({row, col})
            {3'd0, 3'd0}: c = "e";
            {3'd0, 3'd1}: c = "s";
            {3'd0, 3'd2}: c = "m";
            {3'd0, 3'd3}: c = "p";
            {3'd0, 3'd4}: c = "i";
            {3'd1, 3'd0}: c = "o";
            {3'd1, 3'd1}: c = "c";
            {3'd1, 3'd2}: c = "h";
            {3'd1, 3'd3}: c = "a";
            {3'd1, 3'd4}: c = "v";
            {3'd2, 3'd0}: c = "b";
            {3'd2, 3'd1}: c = "d";
            {3'd2, 3'd2}: c = "f";
            {3'd2, 3'd3}: c = "g";
            {3'd2, 3'd4}: c = "k";
            {3'd3, 3'd0}: c = "l";
            {3'd3, 3'd1}: c = "n";
            {3'd3, 3'd2}: c = "q";
            {3'd3, 3'd3}: c = "r";
            {3'd3, 3'd4}: c = "t";
            {3'd4, 3'd0}: c = "u";
            {3'd4, 3'd1}: c = "w";
            {3'd4, 3'd2}: c = "x";
            {3'd4, 3'd3}: c = "y";
            {3'd4, 3'd4}: c = "z";
            default:      c = "e";
        endcase
        return c[6:0];
    endfunction

    function automatic logic [2:0] pfe_wrap_inc(input logic [2:0] v);
        return (v == SQ_LAST) ? 3'd0 : v + 3'd1;
    endfunction

    // Row rule, column rule, else rectangle rule.
    function automatic pfe_pair_t pfe_encrypt(input logic [4:0] a, input logic [4:0] b);
        pfe_pos_t  pa;
        pfe_pos_t  pb;
        pfe_pair_t r;
        pa = pfe_place(a);
        pb = pfe_place(b);
        if (pa.row == pb.row) begin
            r.ea = pfe_square(pa.row, pfe_wrap_inc(pa.col));
            r.eb = pfe_square(pb.row, pfe_wrap_inc(pb.col));
        end
        else if (pa.col == pb.col) begin
            r.ea = pfe_square(pfe_wrap_inc(pa.row), pa.col);
            r.eb = pfe_square(pfe_wrap_inc(pb.row), pb.col);
        end
        else begin
            r.ea = pfe_square(pa.row, pb.col);
            r.eb = pfe_square(pb.row, pa.col);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/playfair_digraph_encryptor.sv @@
// Top level of the Playfair digraph encryptor: front end, job queue and
// cipher back end. Depends on pfe_pkg, pfe_front, pfe_queue and pfe_back.
//
// Plaintext letters are requested one per cycle while full is low. Every second
// letter (or a doubled letter, or a final letter) turns into a digraph job in a
// QUEUE_DEPTH-entry queue; while pop is high the back end drains each job at one
// cipher letter per cycle, two letters per job, four when a doubled final letter
// is padded twice. Output letter rate is the limit: while pop is high, a plain
// message sustains one input letter per cycle; each doubled letter costs two extra
// output letters. With the back end idle, a completed digraph is registered as a
// queued job, then its first cipher letter in the output register that drives the
// result ports. run_end marks the last cipher letter of each request.
`default_nettype none

module playfair_digraph_encryptor
    import pfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [6:0] letter,
    input  wire logic       is_last,
    output logic            empty,
    input  wire logic       pop,
    output logic [6:0]      cipher_letter,
    output logic            run_end
);

    pfe_job_t new_job;
    pfe_job_t head_job;
    logic     accept;
    logic     job_push;
    logic     pend_valid;
    logic     head_valid;
    logic     deq;

    assign accept = push && !full;

    pfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .letter     (letter),
        .is_last    (is_last),
        .job        (new_job),
        .job_push   (job_push),
        .pend_valid (pend_valid)
    );

    pfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .enq        (job_push),
        .enq_job    (new_job),
        .full       (full),
        .deq        (deq),
        .head_job   (head_job),
        .head_valid (head_valid)
    );

    pfe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .head_valid    (head_valid),
        .deq           (deq),
        .cipher_letter (cipher_letter),
        .run_end       (run_end),
        .empty         (empty),
        .pop           (pop)
    );

    // A final letter always leaves nothing pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_last |=> !pend_valid)
        else $error("pending letter survived a final letter");

    // Jobs leave the queue only while one is there.
    assert property (@(posedge clk) disable iff (!rst_n)
        deq |-> head_valid)
        else $error("dequeue from an empty job queue");

    // The front end issues jobs only for accepted requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> accept)
        else $error("job issued without an accepted request");

    // A job leaving the queue loads the final letter of its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        deq |=> !empty && run_end)
        else $error("job retired without a closing letter");

endmodule

`default_nettype wire

@@ hdl/pfe_front.sv @@
// Front end: classifies accepted letters, holds the half-finished digraph and
// issues one digraph job per request at most. Depends on pfe_pkg.
`default_nettype none

module pfe_front
    import pfe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [6:0] letter,
    input  wire logic       is_last,
    output pfe_job_t        job,
    output logic            job_push,
    output logic            pend_valid
);

    logic [4:0] pend_letter_reg;
    logic [4:0] pend_letter_next;
    logic       pend_valid_reg;
    logic       pend_valid_next;
    logic       in_range;
    logic [4:0] raw_idx;
    logic [4:0] cur;

    assign in_range = (letter >= ASCII_A) && (letter <= ASCII_Z);
    assign raw_idx  = 5'(letter - ASCII_A);
    assign cur      = (raw_idx == LTR_J) ? LTR_I : raw_idx;

    always_comb
    begin
        pend_letter_next = pend_letter_reg;
        pend_valid_next  = pend_valid_reg;
        job_push         = 1'b0;
        job.first        = pend_letter_reg;
        job.second       = pfe_filler(pend_letter_reg);
        job.twice        = 1'b0;
        if (accept)
        begin
            if (!in_range)
            begin
                // flush a waiting letter at end of message
                if (is_last && pend_valid_reg)
                begin
                    job_push        = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            else if (pend_valid_reg)
            begin
                job_push = 1'b1;
                if (pend_letter_reg == cur)
                begin
                    // doubled letter: pad it, and pad the repeat too when last
                    job.twice        = is_last;
                    pend_valid_next  = !is_last;
                    pend_letter_next = cur;
                end
                else
                begin
                    job.second      = cur;
                    pend_valid_next = 1'b0;
                end
            end
            else if (is_last)
            begin
                job_push   = 1'b1;
                job.first  = cur;
                job.second = pfe_filler(cur);
            end
            else
            begin
                pend_letter_next = cur;
                pend_valid_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_letter_reg <= '0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_letter_reg <= pend_letter_next;
            pend_valid_reg  <= pend_valid_next;
        end
    end

    assign pend_valid = pend_valid_reg;

endmodule

`default_nettype wire

@@ hdl/pfe_queue.sv @@
// Short job queue between the front end and the cipher back end.
// Depends on pfe_pkg.
`default_nettype none

module pfe_queue
    import pfe_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     enq,
    input  wire pfe_job_t enq_job,
    output logic          full,
    input  wire logic     deq,
    output pfe_job_t      head_job,
    output logic          head_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE   = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    pfe_job_t         job_mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_rd;

    assign full       = (count_reg == CNT_DEPTH);
    assign head_valid = (count_reg != '0);
    assign head_job   = job_mem_reg[rd_ptr_reg];
    assign do_rd      = deq && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (enq)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        case ({enq, do_rd})
            2'b10:   count_next = count_reg + CNT_ONE;
            2'b01:   count_next = count_reg - CNT_ONE;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (enq)
            job_mem_reg[wr_ptr_reg] <= enq_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/pfe_back.sv @@
// Back end: enciphers the head digraph and streams its letters, one per
// cycle while pop is high, through the output register. Depends on pfe_pkg.
`default_nettype none

module pfe_back
    import pfe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire pfe_job_t   head_job,
    input  wire logic       head_valid,
    output logic            deq,
    output logic [6:0]      cipher_letter,
    output logic            run_end,
    output logic            empty,
    input  wire logic       pop
);

    pfe_pair_t  pair;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [6:0] letter_reg;
    logic [6:0] letter_next;
    logic       run_end_reg;
    logic       run_end_next;
    logic       load;
    logic       last_letter;

    assign pair        = pfe_encrypt(head_job.first, head_job.second);
    assign load        = head_valid && (!out_valid_reg || pop);
    assign last_letter = ((phase_reg == 2'd1) && !head_job.twice) || (phase_reg == 2'd3);
    assign deq         = load && last_letter;

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !pop;
        letter_next    = letter_reg;
        run_end_next   = run_end_reg;
        if (load)
        begin
            // advance within the job; a doubled job replays the same pair
            phase_next     = last_letter ? 2'd0 : phase_reg + 2'd1;
            out_valid_next = 1'b1;
            letter_next    = phase_reg[0] ? pair.eb : pair.ea;
            run_end_next   = last_letter;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        letter_reg  <= letter_next;
        run_end_reg <= run_end_next;
    end

    assign cipher_letter = letter_reg;
    assign run_end       = run_end_reg;
    assign empty         = !out_valid_reg;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for playfair_digraph_encryptor: directed and random
// plaintext messages, with a built-in Playfair predictor checking every cipher letter.
// Depends on pfe_pkg and the playfair_digraph_encryptor RTL.
`default_nettype none

module tb;
    import pfe_pkg::*;

    localparam int N_LIVE_TARGET  = 450;
    localparam int QUIET_TAIL     = 60;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [6:0] letter;
        logic       is_last;
    } plain_req_t;

    typedef struct {
        logic [6:0] letter;
        logic       run_end;
    } cipher_exp_t;

    // Key square, row-major, and the square position of each letter index.
    byte unsigned key_sq [25] = '{
        "e", "s", "m", "p", "i",
        "o", "c", "h", "a", "v",
        "b", "d", "f", "g", "k",
        "l", "n", "q", "r", "t",
        "u", "w", "x", "y", "z"
    };
    int sq_pos [26] = '{
        8, 10, 6, 11, 0, 12, 13, 7, 4, 4, 14, 15, 2,
        16, 5, 3, 17, 18, 1, 19, 20, 9, 21, 22, 23, 24
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [6:0] letter = '0;
    logic       is_last = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [6:0] cipher_letter;
    logic       run_end;

    plain_req_t  plaintext_q [$];
    cipher_exp_t cipher_q [$];

    logic [4:0] held_idx = '0;
    logic       held_valid = 1'b0;

    int n_live;
    int n_accepted;
    int n_checked;
    int n_doubled;
    int n_padded;
    int err_count;
    int send_gap;
    int stall_gap;
    int idle_run;

    playfair_digraph_encryptor i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .letter       (letter),
        .is_last      (is_last),
        .empty        (empty),
        .pop          (pop),
        .cipher_letter(cipher_letter),
        .run_end      (run_end)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [4:0] filler_for(input logic [4:0] idx);
        return (idx == LTR_X) ? LTR_Q : LTR_X;
    endfunction

    function automatic logic [6:0] stray_code();
        logic [6:0] c;
        c = 7'($urandom_range(0, 127));
        while (c >= ASCII_A && c <= ASCII_Z)
            c = 7'($urandom_range(0, 127));
        return c;
    endfunction

    // Encrypt one digraph of letter indices and queue both cipher letters.
    task automatic queue_digraph(input logic [4:0] a, input logic [4:0] b);
        int pa;
        int pb;
        int ra;
        int ca;
        int rb;
        int cb;
        int ea;
        int eb;
        cipher_exp_t e;
        pa = sq_pos[a];
        pb = sq_pos[b];
        ra = pa / 5;
        ca = pa % 5;
        rb = pb / 5;
        cb = pb % 5;
        if (ra == rb)
        begin
            ea = ra * 5 + (ca + 1) % 5;
            eb = rb * 5 + (cb + 1) % 5;
        end
        else if (ca == cb)
        begin
            ea = ((ra + 1) % 5) * 5 + ca;
            eb = ((rb + 1) % 5) * 5 + cb;
        end
        else
        begin
            ea = ra * 5 + cb;
            eb = rb * 5 + ca;
        end
        e.run_end = 1'b0;
        e.letter = key_sq[ea][6:0];
        cipher_q.push_back(e);
        e.letter = key_sq[eb][6:0];
        cipher_q.push_back(e);
    endtask

    task automatic predict_cipher(input logic [6:0] ch, input logic last);
        int         depth_in;
        logic [4:0] cur;
        depth_in = cipher_q.size();
        if (ch < ASCII_A || ch > ASCII_Z)
        begin
            if (last && held_valid)
            begin
                queue_digraph(held_idx, filler_for(held_idx));
                held_valid = 1'b0;
                held_idx = '0;
                n_padded++;
            end
        end
        else
        begin
            cur = 5'(ch - ASCII_A);
            if (cur == LTR_J)
                cur = LTR_I;
            if (held_valid && held_idx == cur)
            begin
                queue_digraph(held_idx, filler_for(held_idx));
                n_doubled++;
                if (last)
                begin
                    queue_digraph(cur, filler_for(cur));
                    held_valid = 1'b0;
                    held_idx = '0;
                    n_padded++;
                end
            end
            else if (held_valid)
            begin
                queue_digraph(held_idx, cur);
                held_valid = 1'b0;
                held_idx = '0;
            end
            else if (last)
            begin
                queue_digraph(cur, filler_for(cur));
                n_padded++;
            end
            else
            begin
                held_idx = cur;
                held_valid = 1'b1;
            end
        end
        if (cipher_q.size() > depth_in)
            cipher_q[cipher_q.size() - 1].run_end = 1'b1;
    endtask

    task automatic add_plain(input logic [7:0] code, input logic last);
        plain_req_t r;
        r.letter = code[6:0];
        r.is_last = last;
        plaintext_q.push_back(r);
        if (last || (r.letter >= ASCII_A && r.letter <= ASCII_Z))
            n_live++;
    endtask

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Request driver: predict on acceptance, hold while full, random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        plain_req_t r;
        if (!rst_n)
        begin
            push <= 1'b0;
            letter <= '0;
            is_last <= 1'b0;
            send_gap = 0;
        end
        else if (!(push && full))
        begin
            if (push)
            begin
                predict_cipher(letter, is_last);
                n_accepted++;
            end
            if (send_gap > 0)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (plaintext_q.size() == 0)
                push <= 1'b0;
            else if (plaintext_q.size() > QUIET_TAIL && $urandom_range(0, 6) == 0)
            begin
                send_gap = $urandom_range(0, 2);
                push <= 1'b0;
            end
            else
            begin
                r = plaintext_q.pop_front();
                push <= 1'b1;
                letter <= r.letter;
                is_last <= r.is_last;
            end
        end
    end

    // Result monitor: check the oldest expectation, random stall bursts.
    always @(posedge clk or negedge rst_n)
    begin
        cipher_exp_t e;
        if (!rst_n)
        begin
            pop <= 1'b0;
            stall_gap = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (cipher_q.size() == 0)
                    report_mismatch($sformatf("unexpected cipher letter %c run_end=%0b",
                                              cipher_letter, run_end));
                else
                begin
                    e = cipher_q.pop_front();
                    n_checked++;
                    if (cipher_letter !== e.letter)
                        report_mismatch($sformatf("cipher_letter exp %c (%0d) got %c (%0d)",
                                                  e.letter, e.letter,
                                                  cipher_letter, cipher_letter));
                    if (run_end !== e.run_end)
                        report_mismatch($sformatf("run_end exp %0b got %0b at letter %c",
                                                  e.run_end, run_end, e.letter));
                end
            end
            if (stall_gap > 0)
            begin
                stall_gap--;
                pop <= 1'b0;
            end
            else if (plaintext_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
            begin
                stall_gap = $urandom_range(0, 2);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no request or result moved for %0d cycles, %0d letters pending",
                     WATCHDOG_LIMIT, cipher_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int         msg_len;
        int         k;
        logic [6:0] ch;
        logic [6:0] prev;
        logic       last;

        // Edge letters, each square rule, i/j merge, doubles, padding, stray codes.
        add_plain("a", 1'b0);
        add_plain("z", 1'b0);
        add_plain("e", 1'b0);
        add_plain("i", 1'b0);
        add_plain("p", 1'b0);
        add_plain("y", 1'b0);
        add_plain("j", 1'b0);
        add_plain("s", 1'b0);
        add_plain("l", 1'b0);
        add_plain("l", 1'b0);
        add_plain("o", 1'b0);
        add_plain("x", 1'b0);
        add_plain("x", 1'b0);
        add_plain("a", 1'b0);
        add_plain("e", 1'b0);
        add_plain("e", 1'b1);
        add_plain("k", 1'b1);
        add_plain("x", 1'b1);
        add_plain(8'd0, 1'b0);
        add_plain("m", 1'b0);
        add_plain(8'd127, 1'b1);
        add_plain(8'd96, 1'b1);
        add_plain("i", 1'b0);
        add_plain("j", 1'b1);
        add_plain(8'd123, 1'b0);

        // Random messages: mostly clean text with repeats, some stray codes,
        // some ending on a stray code, some running into the next message.
        while (n_live < N_LIVE_TARGET)
        begin
            msg_len = $urandom_range(1, 12);
            prev = ASCII_A;
            for (k = 0; k < msg_len; k++)
            begin
                last = (k == msg_len - 1) && ($urandom_range(0, 9) != 0);
                if ($urandom_range(0, 19) == 0)
                    ch = 7'($urandom_range(0, 127));
                else if (k > 0 && $urandom_range(0, 4) == 0)
                    ch = prev;
                else if (last && $urandom_range(0, 9) == 0)
                    ch = stray_code();
                else
                    ch = ASCII_A + 7'($urandom_range(0, 25));
                add_plain({1'b0, ch}, last);
                prev = ch;
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (plaintext_q.size() != 0 || push || cipher_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d plaintext requests, checked %0d cipher letters", n_accepted, n_checked);
        $display("Covered %0d doubled-letter fills and %0d end-of-message pads, %0d mismatches",
                 n_doubled, n_padded, err_count);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
